// ----- sv/gnz_pkg.sv -----
// ----------------------------------------------------------------------------
// gnz_pkg
// Shared constants for the 3D gradient noise block.
// ----------------------------------------------------------------------------
package gnz_pkg;

  localparam int TABLE_SIZE_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int PERM_W  = 8;
  localparam int COORD_W = 32;
  localparam int NOISE_W = 16;

  // in_tdata layout
  localparam int PIDX_LSB = 0;
  localparam int PVAL_LSB = PIDX_LSB + PERM_W;
  localparam int CX_LSB   = PVAL_LSB + PERM_W;
  localparam int CY_LSB   = CX_LSB + COORD_W;
  localparam int CZ_LSB   = CY_LSB + COORD_W;
  localparam int IN_W     = CZ_LSB + COORD_W;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

endpackage

// ----- sv/gnz_ram.sv -----
// ----------------------------------------------------------------------------
// gnz_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gnz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/gradient_noise_3d.sv -----
// ----------------------------------------------------------------------------
// gradient_noise_3d
// 3D improved gradient noise evaluator with a loadable permutation table.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle when the output is not stalled, loads
// and evaluations alike; an accepted evaluation moves down the stages to the
// output register. The permutation table is held as fourteen RAM copies, one
// per lookup of the three dependent hash levels (two, four and eight reads);
// a load walks down the pipeline and writes each level's copies at the stage
// where that level reads, so loads and evaluations stay in order. TABLE_SIZE
// must be a power of two. All table entries must be loaded before the first
// evaluation. A stalled output stalls the whole pipeline.
module gradient_noise_3d #(
  parameter int TABLE_SIZE = gnz_pkg::TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = gnz_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // perm_index, perm_value, coord_x, coord_y, coord_z
  input  logic [gnz_pkg::IN_W-1:0]    in_tdata,
  // action
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // noise_value
  output logic [gnz_pkg::NOISE_W-1:0] out_tdata
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int VW = FRAC_BITS + 6;
  localparam int PW = 2 * VW;
  localparam int QW = VW + 18;
  localparam int PWD = gnz_pkg::PERM_W;
  localparam logic signed [VW-1:0] ONE_V  = VW'(1) <<< FRAC_BITS;
  localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (FRAC_BITS - 1);

  function automatic logic signed [VW-1:0] mulq(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic signed [PW-1:0] p;
    p = a * b + HALF_P;
    return p[FRAC_BITS +: VW];
  endfunction

  function automatic logic [IW-1:0] wrap_add(input logic [PWD-1:0] p,
                                             input logic [IW-1:0] c);
    logic [IW+PWD-1:0] s;
    s = {{IW{1'b0}}, p} + {{PWD{1'b0}}, c};
    return s[IW-1:0];
  endfunction

  function automatic logic signed [VW-1:0] grad(input logic [3:0] h,
                                                input logic signed [VW-1:0] x,
                                                input logic signed [VW-1:0] y,
                                                input logic signed [VW-1:0] z);
    logic signed [VW-1:0] gu;
    logic signed [VW-1:0] gv;
    gu = h[3] ? y : x;
    if (h[3:2] == 2'b00) begin
      gv = y;
    end else if (h[3:2] == 2'b11 && !h[0]) begin
      gv = x;
    end else begin
      gv = z;
    end
    return (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
  endfunction

  logic adv;
  logic acc;

  // stage registers
  logic                    s1_ev_r, s2_ev_r, s3_ev_r, s4_ev_r, s5_ev_r, s6_ev_r, s7_ev_r;
  logic                    s1_ld_r, s2_ld_r;
  logic [IW-1:0]           s1_lidx_r, s2_lidx_r;
  logic [PWD-1:0]          s1_lval_r, s2_lval_r;
  logic [FRAC_BITS-1:0]    s1_frac_r [3];
  logic [FRAC_BITS-1:0]    s2_frac_r [3];
  logic [FRAC_BITS-1:0]    s3_frac_r [3];
  logic [IW-1:0]           s1_cy_r, s1_cz_r, s2_cz_r;
  logic signed [VW-1:0]    s1_m_r [3];
  logic signed [VW-1:0]    s2_m_r [3];
  logic signed [VW-1:0]    s3_m_r [3];
  logic signed [VW-1:0]    s4_fade_r [3];
  logic signed [VW-1:0]    s4_dot_r [8];
  logic signed [VW-1:0]    s5_e_r [4];
  logic signed [VW-1:0]    s5_v_r, s5_w_r, s6_w_r;
  logic signed [VW-1:0]    s6_lo_r, s6_hi_r, s7_r_r;
  logic                    out_valid_r;
  logic [gnz_pkg::NOISE_W-1:0] noise_r;

  // next values
  logic [FRAC_BITS-1:0]    frac_nxt [3];
  logic [IW-1:0]           cell_nxt [3];
  logic signed [VW-1:0]    m1_nxt [3];
  logic signed [VW-1:0]    m2_nxt [3];
  logic signed [VW-1:0]    m3_nxt [3];
  logic signed [VW-1:0]    fade_nxt [3];
  logic signed [VW-1:0]    dot_nxt [8];
  logic signed [VW-1:0]    e_nxt [4];
  logic signed [VW-1:0]    lo_nxt, hi_nxt, r_nxt;
  logic [gnz_pkg::NOISE_W-1:0] noise_nxt;
  logic                    out_valid_nxt;
  logic [IW-1:0]           lidx_nxt;

  // table copies
  logic [IW-1:0]  l1_addr [2];
  logic [PWD-1:0] l1_data [2];
  logic [IW-1:0]  l2_addr [4];
  logic [PWD-1:0] l2_data [4];
  logic [IW-1:0]  l3_addr [8];
  logic [PWD-1:0] l3_data [8];
  logic [IW-1:0]  base_a, base_b;
  logic [IW-1:0]  hb [4];

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;
  assign lidx_nxt  = wrap_add(in_tdata[gnz_pkg::PIDX_LSB +: PWD], '0);

  // input split and first fade product
  always_comb begin
    logic [gnz_pkg::COORD_W-1:0] c;
    logic signed [gnz_pkg::COORD_W-1:0] sh;
    logic signed [VW-1:0] t;
    for (int i = 0; i < 3; i++) begin
      c = in_tdata[gnz_pkg::CX_LSB + i * gnz_pkg::COORD_W +: gnz_pkg::COORD_W];
      sh = $signed(c) >>> FRAC_BITS;
      frac_nxt[i] = c[FRAC_BITS-1:0];
      cell_nxt[i] = sh[IW-1:0];
      t = $signed({{(VW-FRAC_BITS){1'b0}}, c[FRAC_BITS-1:0]});
      m1_nxt[i] = mulq(t, VW'(6) * t - VW'(15) * ONE_V);
    end
  end

  assign l1_addr[0] = cell_nxt[0];
  assign l1_addr[1] = cell_nxt[0] + IW'(1);

  // second level addresses and fade
  always_comb begin
    logic signed [VW-1:0] t;
    base_a = wrap_add(l1_data[0], s1_cy_r);
    base_b = wrap_add(l1_data[1], s1_cy_r);
    for (int j = 0; j < 4; j++) begin
      l2_addr[j] = (j[1] ? base_b : base_a) + IW'(j[0]);
    end
    for (int i = 0; i < 3; i++) begin
      t = $signed({{(VW-FRAC_BITS){1'b0}}, s1_frac_r[i]});
      m2_nxt[i] = mulq(t, s1_m_r[i] + VW'(10) * ONE_V);
    end
  end

  // third level addresses and fade
  always_comb begin
    logic signed [VW-1:0] t;
    for (int j = 0; j < 4; j++) begin
      hb[j] = wrap_add(l2_data[j], s2_cz_r);
    end
    for (int k = 0; k < 8; k++) begin
      l3_addr[k] = hb[{k[0], k[1]}] + IW'(k[2]);
    end
    for (int i = 0; i < 3; i++) begin
      t = $signed({{(VW-FRAC_BITS){1'b0}}, s2_frac_r[i]});
      m3_nxt[i] = mulq(t, s2_m_r[i]);
    end
  end

  // corner gradients and last fade product
  always_comb begin
    logic signed [VW-1:0] p0 [3];
    logic signed [VW-1:0] p1 [3];
    for (int i = 0; i < 3; i++) begin
      p0[i] = $signed({{(VW-FRAC_BITS){1'b0}}, s3_frac_r[i]});
      p1[i] = p0[i] - ONE_V;
      fade_nxt[i] = mulq(p0[i], s3_m_r[i]);
    end
    for (int k = 0; k < 8; k++) begin
      dot_nxt[k] = grad(l3_data[k][3:0],
                        k[0] ? p1[0] : p0[0],
                        k[1] ? p1[1] : p0[1],
                        k[2] ? p1[2] : p0[2]);
    end
  end

  // trilinear blend
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      e_nxt[j] = s4_dot_r[2*j] + mulq(s4_fade_r[0], s4_dot_r[2*j+1] - s4_dot_r[2*j]);
    end
    lo_nxt = s5_e_r[0] + mulq(s5_v_r, s5_e_r[1] - s5_e_r[0]);
    hi_nxt = s5_e_r[2] + mulq(s5_v_r, s5_e_r[3] - s5_e_r[2]);
    r_nxt  = s6_lo_r + mulq(s6_w_r, s6_hi_r - s6_lo_r);
  end

  // map to unsigned Q0.16
  always_comb begin
    logic signed [VW:0] val;
    logic [VW:0]        valc;
    logic [QW-1:0]      num;
    logic [QW-1:0]      q;
    val = {s7_r_r[VW-1], s7_r_r} + {ONE_V[VW-1], ONE_V};
    if (val < 0) begin
      valc = '0;
    end else if (val > ({ONE_V, 1'b0})) begin
      valc = {ONE_V, 1'b0};
    end else begin
      valc = val;
    end
    num = ({{(QW-VW-1){1'b0}}, valc} << gnz_pkg::NOISE_W) + (QW'(1) << FRAC_BITS);
    q   = num >> (FRAC_BITS + 1);
    if (q > QW'(16'hFFFF)) begin
      noise_nxt = '1;
    end else begin
      noise_nxt = q[gnz_pkg::NOISE_W-1:0];
    end
  end

  assign out_valid_nxt = adv ? s7_ev_r : out_valid_r;

  for (genvar g = 0; g < 2; g++) begin : g_l1
    gnz_ram #(.WIDTH(PWD), .DEPTH(TABLE_SIZE)) u_ram (
      .clk   (clk),
      .we    (acc && in_tuser == gnz_pkg::ACT_LOAD),
      .waddr (lidx_nxt),
      .wdata (in_tdata[gnz_pkg::PVAL_LSB +: PWD]),
      .re    (adv),
      .raddr (l1_addr[g]),
      .rdata (l1_data[g])
    );
  end

  for (genvar g = 0; g < 4; g++) begin : g_l2
    gnz_ram #(.WIDTH(PWD), .DEPTH(TABLE_SIZE)) u_ram (
      .clk   (clk),
      .we    (adv && s1_ld_r),
      .waddr (s1_lidx_r),
      .wdata (s1_lval_r),
      .re    (adv),
      .raddr (l2_addr[g]),
      .rdata (l2_data[g])
    );
  end

  for (genvar g = 0; g < 8; g++) begin : g_l3
    gnz_ram #(.WIDTH(PWD), .DEPTH(TABLE_SIZE)) u_ram (
      .clk   (clk),
      .we    (adv && s2_ld_r),
      .waddr (s2_lidx_r),
      .wdata (s2_lval_r),
      .re    (adv),
      .raddr (l3_addr[g]),
      .rdata (l3_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ev_r     <= 1'b0;
      s2_ev_r     <= 1'b0;
      s3_ev_r     <= 1'b0;
      s4_ev_r     <= 1'b0;
      s5_ev_r     <= 1'b0;
      s6_ev_r     <= 1'b0;
      s7_ev_r     <= 1'b0;
      s1_ld_r     <= 1'b0;
      s2_ld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        s1_ev_r <= acc && in_tuser == gnz_pkg::ACT_EVAL;
        s1_ld_r <= acc && in_tuser == gnz_pkg::ACT_LOAD;
        s2_ev_r <= s1_ev_r;
        s2_ld_r <= s1_ld_r;
        s3_ev_r <= s2_ev_r;
        s4_ev_r <= s3_ev_r;
        s5_ev_r <= s4_ev_r;
        s6_ev_r <= s5_ev_r;
        s7_ev_r <= s6_ev_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_lidx_r <= lidx_nxt;
      s1_lval_r <= in_tdata[gnz_pkg::PVAL_LSB +: PWD];
      s1_cy_r   <= cell_nxt[1];
      s1_cz_r   <= cell_nxt[2];
      s2_lidx_r <= s1_lidx_r;
      s2_lval_r <= s1_lval_r;
      s2_cz_r   <= s1_cz_r;
      for (int i = 0; i < 3; i++) begin
        s1_frac_r[i] <= frac_nxt[i];
        s2_frac_r[i] <= s1_frac_r[i];
        s3_frac_r[i] <= s2_frac_r[i];
        s1_m_r[i]    <= m1_nxt[i];
        s2_m_r[i]    <= m2_nxt[i];
        s3_m_r[i]    <= m3_nxt[i];
        s4_fade_r[i] <= fade_nxt[i];
      end
      for (int k = 0; k < 8; k++) begin
        s4_dot_r[k] <= dot_nxt[k];
      end
      for (int j = 0; j < 4; j++) begin
        s5_e_r[j] <= e_nxt[j];
      end
      s5_v_r  <= s4_fade_r[1];
      s5_w_r  <= s4_fade_r[2];
      s6_w_r  <= s5_w_r;
      s6_lo_r <= lo_nxt;
      s6_hi_r <= hi_nxt;
      s7_r_r  <= r_nxt;
      if (s7_ev_r) begin
        noise_r <= noise_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = noise_r;

`ifndef SYNTH
  a_slot_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_ev_r && s1_ld_r) && !(s2_ev_r && s2_ld_r))
    else $error("load and evaluate share a pipeline slot");

  a_load_enters: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tuser == gnz_pkg::ACT_LOAD |=> s1_ld_r)
    else $error("accepted load lost at first stage");

  a_result_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s7_ev_r && adv |=> out_tvalid)
    else $error("finished result not presented");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s7_ev_r) && $stable(s4_ev_r) && $stable(s1_ev_r))
    else $error("pipeline moved while stalled");
`endif

endmodule

// ----- tb/gradient_noise_3d_tb.sv -----
// ----------------------------------------------------------------------------
// gradient_noise_3d_tb
// Self-checking testbench for the 3D gradient noise evaluator. The whole
// permutation table is loaded first. Directed points at coordinate extremes
// and two reloads follow, then a random mix of evaluations and table reloads.
// Random gaps and stalls are applied on both streams.
// ----------------------------------------------------------------------------
module gradient_noise_3d_tb;

  localparam longint ONE_Q = 64'sd1 << gnz_pkg::FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 600000;

  class noise_scoreboard;
    bit [7:0]  perm [256];
    bit [15:0] pending_noise [$];
    int        errors;
    int        n_loads;
    int        n_evals;

    function longint floor_div(longint p);
      longint q;
      q = p / ONE_Q;
      if (p % ONE_Q < 0) q--;
      return q;
    endfunction

    function longint mulq(longint a, longint b);
      return floor_div(a * b + ONE_Q / 2);
    endfunction

    function longint fade(longint t);
      longint s;
      s = 6 * t - 15 * ONE_Q;
      s = mulq(t, s) + 10 * ONE_Q;
      s = mulq(t, s);
      s = mulq(t, s);
      return mulq(t, s);
    endfunction

    function longint lerp(longint t, longint a, longint b);
      return a + mulq(t, b - a);
    endfunction

    function longint grad(int hash, longint x, longint y, longint z);
      bit [3:0] h;
      longint u;
      longint v;
      h = hash[3:0];
      u = (h < 8) ? x : y;
      v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function int pat(int i);
      return perm[i[7:0]];
    endfunction

    function void split(bit [31:0] raw, output int cell_idx, output longint fr);
      longint c;
      c = longint'(signed'(raw));
      fr = c & (ONE_Q - 1);
      cell_idx = int'((c - fr) / ONE_Q) & 255;
    endfunction

    function bit [15:0] noise_at(bit [31:0] rx, bit [31:0] ry, bit [31:0] rz);
      int cx, cy, cz, a, aa, ab, b, ba, bb;
      longint x, y, z, u, v, w, x1, y1, z1, lo, hi, r, val, q;
      split(rx, cx, x);
      split(ry, cy, y);
      split(rz, cz, z);
      u = fade(x);
      v = fade(y);
      w = fade(z);
      a = pat(cx) + cy;
      aa = pat(a) + cz;
      ab = pat(a + 1) + cz;
      b = pat(cx + 1) + cy;
      ba = pat(b) + cz;
      bb = pat(b + 1) + cz;
      x1 = x - ONE_Q;
      y1 = y - ONE_Q;
      z1 = z - ONE_Q;
      lo = lerp(v, lerp(u, grad(pat(aa), x, y, z), grad(pat(ba), x1, y, z)),
                   lerp(u, grad(pat(ab), x, y1, z), grad(pat(bb), x1, y1, z)));
      hi = lerp(v, lerp(u, grad(pat(aa + 1), x, y, z1), grad(pat(ba + 1), x1, y, z1)),
                   lerp(u, grad(pat(ab + 1), x, y1, z1), grad(pat(bb + 1), x1, y1, z1)));
      r = lerp(w, lo, hi);
      val = r + ONE_Q;
      if (val < 0) val = 0;
      if (val > 2 * ONE_Q) val = 2 * ONE_Q;
      q = (val * 65536 + ONE_Q) / (2 * ONE_Q);
      if (q > 65535) q = 65535;
      return q[15:0];
    endfunction

    function void note_transaction(logic act, logic [gnz_pkg::IN_W-1:0] d);
      if (act == gnz_pkg::ACT_LOAD) begin
        perm[d[gnz_pkg::PIDX_LSB +: gnz_pkg::PERM_W]] = d[gnz_pkg::PVAL_LSB +: gnz_pkg::PERM_W];
        n_loads++;
      end else begin
        pending_noise.push_back(noise_at(d[gnz_pkg::CX_LSB +: gnz_pkg::COORD_W],
                                         d[gnz_pkg::CY_LSB +: gnz_pkg::COORD_W],
                                         d[gnz_pkg::CZ_LSB +: gnz_pkg::COORD_W]));
        n_evals++;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(logic [gnz_pkg::NOISE_W-1:0] got);
      bit [15:0] want;
      if (pending_noise.size() == 0) begin
        report($sformatf("unexpected noise_value %h", got));
      end else begin
        want = pending_noise.pop_front();
        if (got !== want)
          report($sformatf("noise_value got %h want %h", got, want));
      end
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [gnz_pkg::IN_W-1:0]     in_tdata = '0;
  logic                         in_tuser = gnz_pkg::ACT_LOAD;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [gnz_pkg::NOISE_W-1:0]  out_tdata;

  noise_scoreboard sb = new();
  int  cycles = 0;
  bit  no_stall = 1'b0;
  int  stall_left = 0;

  gradient_noise_3d dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #2 clk = ~clk;

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_transaction(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if (no_stall || stall_left == 0) begin
      out_tready <= 1'b1;
      if (!no_stall) stall_left <= gap_len();
    end else begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end
  end

  task send(logic act, bit [7:0] idx, bit [7:0] pv,
            bit [31:0] cx, bit [31:0] cy, bit [31:0] cz, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {cz, cy, cx, pv, idx};
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  task load(bit [7:0] idx, bit [7:0] pv, int gap);
    send(gnz_pkg::ACT_LOAD, idx, pv, $urandom, $urandom, $urandom, gap);
  endtask

  task eval(bit [31:0] cx, bit [31:0] cy, bit [31:0] cz, int gap);
    send(gnz_pkg::ACT_EVAL, 8'($urandom), 8'($urandom), cx, cy, cz, gap);
  endtask

  function bit [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return {{16{1'b0}}, 16'($urandom)};
      2: return {{16{1'b1}}, 16'($urandom)};
      3: return {16'($urandom), 16'h0000};
      4: return {16'($urandom), 16'hFFFF};
      default: return 32'($signed(10'($urandom)) * 4096);
    endcase
  endfunction

  initial begin
    bit [31:0] pts [12];
    int i;
    pts = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
            32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
            32'hFFFF_8000, 32'h00FF_0001, 32'hFF00_FFFF, 32'h0000_0001};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 256; i++) load(i[7:0], 8'($urandom), (i < 128) ? 0 : gap_len());
    no_stall = 1'b1;
    for (i = 0; i < 12; i++) eval(pts[i], pts[(i + 3) % 12], pts[(i + 7) % 12], 0);
    eval(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    eval(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    load(8'h00, 8'hFF, 0);
    load(8'hFF, 8'h00, 0);
    eval(32'hFFFF_FFFF, 32'h0000_0000, 32'h00FF_FFFF, 0);
    eval(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 0);
    no_stall = 1'b0;

    in_tvalid <= 1'b0;
    while (sb.pending_noise.size() != 0) @(posedge clk);

    for (i = 0; i < 230; i++) begin
      if (i % 100 == 50) no_stall = ~no_stall;
      if ($urandom_range(0, 9) == 0) load(8'($urandom), 8'($urandom), gap_len());
      else eval(rand_coord(), rand_coord(), rand_coord(), gap_len());
    end
    in_tvalid <= 1'b0;
    no_stall = 1'b0;

    while (sb.pending_noise.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("covered %0d table loads and %0d noise evaluations", sb.n_loads, sb.n_evals);
    $display("with coordinate extremes, negative cells and table reloads mid-stream");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
